@@ sv/macs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the moving average crossover signal block.
// No dependencies; imported by the interfaces, the core, the divider and the checker.

package macs_pkg;

	// payload widths
	localparam int PRICE_W = 24;
	localparam int KIND_W  = 2;
	localparam int TICK_W  = 32;
	localparam int QTY_W   = 48;
	localparam int TAG_W   = 8;
	localparam int SUM_W   = 32;
	localparam int CAP_W   = 32;
	localparam int LEN_W   = 9;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_SHORT_LEN = 2'd0;
	localparam cfg_idx_t REG_LONG_LEN  = 2'd1;
	localparam cfg_idx_t REG_CAPITAL   = 2'd2;
	localparam cfg_idx_t REG_TAG       = 2'd3;

	// register reset values
	localparam logic [LEN_W-1:0] SHORT_LEN_RST = 9'd5;
	localparam logic [LEN_W-1:0] LONG_LEN_RST  = 9'd20;
	localparam logic [CAP_W-1:0] CAPITAL_RST   = 32'd10000;
	localparam logic [TAG_W-1:0] TAG_RST       = 8'd0;

	// order kinds
	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_BUY  = 2'd0;
	localparam kind_t KIND_SELL = 2'd1;
	localparam kind_t KIND_END  = 2'd2;

endpackage

@@ sv/macs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: price ticks in, orders out.
// Depends on macs_pkg for field widths.

interface macs_in_if;
	import macs_pkg::*;

	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] price;
	logic               final_tick;

	modport source(output valid, price, final_tick, input ready);
	modport sink(input valid, price, final_tick, output ready);
endinterface

interface macs_out_if;
	import macs_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] order_kind;
	logic [TICK_W-1:0] tick_index;
	logic [QTY_W-1:0]  quantity;
	logic [TAG_W-1:0]  tag;
	logic              last_result;

	modport source(output valid, order_kind, tick_index, quantity, tag, last_result,
		input ready);
	modport sink(input valid, order_kind, tick_index, quantity, tag, last_result,
		output ready);
endinterface

@@ sv/macs_div.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on macs_pkg for the quantity and price widths.

module macs_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [macs_pkg::QTY_W-1:0]     dividend,
	input  logic [macs_pkg::PRICE_W-1:0]   divisor,
	output logic                           done,
	output logic [macs_pkg::QTY_W-1:0]     quotient
);
	import macs_pkg::*;

	localparam int CNT_W = $clog2(QTY_W + 1);

	logic [QTY_W-1:0]   quo_q;
	logic [PRICE_W-1:0] rem_q;
	logic [PRICE_W-1:0] dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;

	logic [PRICE_W:0]   trial;
	logic [PRICE_W:0]   diff;
	logic               fits;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[QTY_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QTY_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					run_q <= 1'b0;
			end
		end
	end

	// datapath: quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[QTY_W-2:0], fits};
			rem_q <= fits ? diff[PRICE_W-1:0] : trial[PRICE_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

@@ sv/moving_average_crossover_signal_core.sv @@
`timescale 1ns / 1ps
// Moving average crossover signal core: history ring, window sums, crossover FSM.
// Depends on macs_pkg, macs_in_if / macs_out_if and macs_div.

// One price is taken per transaction and processed alone: the core is ready only
// when its sequencer is idle. A price that causes no order goes from acceptance
// to the next ready through two history reads on the single read port of the
// ring memory, one sum update, two passes through the shared multiplier (32-bit
// sum by window length) and one compare. A price that causes a buy or sell also
// runs the bit-serial divider for the quantity; a zero price skips the divider.
// A final price then emits its end marker from a state of its own. Results leave
// through an output register, so a new price is accepted while the last result
// still waits; a result waits in turn if the register is still full.

module moving_average_crossover_signal_core #(
	parameter int HISTORY_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	macs_in_if.sink                          tick_ch,
	macs_out_if.source                       order_ch,
	input  logic                             cfg_we,
	input  logic [macs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [macs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import macs_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int LW = $clog2(HISTORY_DEPTH + 1);
	localparam int DW = AW + 2;
	localparam int PW = SUM_W + LW;
	localparam logic [DW-1:0] DEPTH_D = DW'(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_PTR = AW'(HISTORY_DEPTH - 1);

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_RD_S     = 10'b00_0000_0010,
		ST_RD_L     = 10'b00_0000_0100,
		ST_UPD      = 10'b00_0000_1000,
		ST_MUL_L    = 10'b00_0001_0000,
		ST_MUL_R    = 10'b00_0010_0000,
		ST_CMP      = 10'b00_0100_0000,
		ST_DIV      = 10'b00_1000_0000,
		ST_EMIT_ORD = 10'b01_0000_0000,
		ST_EMIT_END = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [LEN_W-1:0] short_len_q;
	logic [LEN_W-1:0] long_len_q;
	logic [CAP_W-1:0] capital_q;
	logic [TAG_W-1:0] tag_q;

	// series state
	logic [SUM_W-1:0]  short_sum_q;
	logic [SUM_W-1:0]  long_sum_q;
	logic [TICK_W-1:0] tick_q;
	logic [AW-1:0]     wp_q;
	logic              short_above_q;
	logic              has_bought_q;

	// per-item working registers
	logic [PRICE_W-1:0] price_q;
	logic               final_q;
	logic [PRICE_W-1:0] old_s_q;
	logic [TICK_W-1:0]  ord_tick_q;
	logic [PW-1:0]      lhs_q;
	logic [PW-1:0]      rhs_q;
	logic [KIND_W-1:0]  kind_q;
	logic [QTY_W-1:0]   qty_q;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [TICK_W-1:0] out_tick_q;
	logic [QTY_W-1:0]  out_qty_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic              out_last_q;

	// history ring
	logic [PRICE_W-1:0] hist_mem [HISTORY_DEPTH];
	logic [PRICE_W-1:0] rd_q;
	logic [AW-1:0]      raddr;
	logic               hist_we;

	logic [LW-1:0]      slen;
	logic [LW-1:0]      llen;
	logic [DW-1:0]      diff_s;
	logic [DW-1:0]      diff_l;
	logic [AW-1:0]      addr_s;
	logic [AW-1:0]      addr_l;
	logic               s_full;
	logic               l_full;
	logic [PRICE_W-1:0] old_l;
	logic [SUM_W-1:0]   mul_a;
	logic [LW-1:0]      mul_b;
	logic [PW-1:0]      product;
	logic               slot_free;
	logic               out_load;
	logic               go_up;
	logic               go_down;
	logic               div_start;
	logic               div_done;
	logic [QTY_W-1:0]   div_quo;

	// length clamping: zero acts as one, above depth acts as depth
	always_comb begin
		if (short_len_q == '0)
			slen = LW'(1);
		else if (32'(short_len_q) > 32'(HISTORY_DEPTH))
			slen = LW'(HISTORY_DEPTH);
		else
			slen = LW'(short_len_q);
		if (long_len_q == '0)
			llen = LW'(1);
		else if (32'(long_len_q) > 32'(HISTORY_DEPTH))
			llen = LW'(HISTORY_DEPTH);
		else
			llen = LW'(long_len_q);
	end

	// ring addresses of the prices leaving each window
	always_comb begin
		diff_s = DW'(wp_q) - DW'(slen);
		diff_l = DW'(wp_q) - DW'(llen);
		addr_s = diff_s[DW-1] ? AW'(diff_s + DEPTH_D) : diff_s[AW-1:0];
		addr_l = diff_l[DW-1] ? AW'(diff_l + DEPTH_D) : diff_l[AW-1:0];
		s_full = (tick_q >= TICK_W'(slen));
		l_full = (tick_q >= TICK_W'(llen));
		raddr  = (state_q == ST_RD_S) ? addr_s : addr_l;
		hist_we = (state_q == ST_UPD);
		old_l  = l_full ? rd_q : '0;
	end

	// history memory, registered read
	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[wp_q] <= price_q;
		rd_q <= hist_mem[raddr];
	end

	// shared multiplier: short sum by long length, then long sum by short length
	assign mul_a   = (state_q == ST_MUL_L) ? short_sum_q : long_sum_q;
	assign mul_b   = (state_q == ST_MUL_L) ? llen : slen;
	assign product = PW'(mul_a) * PW'(mul_b);

	// crossing decisions
	assign go_down = short_above_q && (rhs_q > lhs_q);
	assign go_up   = !short_above_q && (lhs_q > rhs_q);

	assign slot_free = !out_valid_q || order_ch.ready;
	assign out_load  = ((state_q == ST_EMIT_ORD) || (state_q == ST_EMIT_END)) && slot_free;
	assign div_start = (state_q == ST_CMP) && ((go_down && has_bought_q) || go_up)
		&& (price_q != '0);

	macs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({capital_q, 16'd0}),
		.divisor  (price_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_len_q <= SHORT_LEN_RST;
			long_len_q  <= LONG_LEN_RST;
			capital_q   <= CAPITAL_RST;
			tag_q       <= TAG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHORT_LEN: short_len_q <= cfg_data[LEN_W-1:0];
				REG_LONG_LEN:  long_len_q  <= cfg_data[LEN_W-1:0];
				REG_CAPITAL:   capital_q   <= cfg_data[CAP_W-1:0];
				REG_TAG:       tag_q       <= cfg_data[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	// output valid: set on a load, cleared when the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (order_ch.ready)
			out_valid_q <= 1'b0;
	end

	// sequencer and series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			short_sum_q   <= '0;
			long_sum_q    <= '0;
			tick_q        <= '0;
			wp_q          <= '0;
			short_above_q <= 1'b1;
			has_bought_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_ch.valid)
						state_q <= ST_RD_S;
				end
				ST_RD_S: state_q <= ST_RD_L;
				ST_RD_L: state_q <= ST_UPD;
				ST_UPD: begin
					short_sum_q <= short_sum_q + SUM_W'(price_q) - SUM_W'(old_s_q);
					long_sum_q  <= long_sum_q + SUM_W'(price_q) - SUM_W'(old_l);
					tick_q      <= tick_q + TICK_W'(1);
					wp_q        <= (wp_q == LAST_PTR) ? '0 : wp_q + AW'(1);
					state_q     <= ST_MUL_L;
				end
				ST_MUL_L: state_q <= ST_MUL_R;
				ST_MUL_R: state_q <= ST_CMP;
				ST_CMP: begin
					if (go_down)
						short_above_q <= 1'b0;
					else if (go_up) begin
						short_above_q <= 1'b1;
						has_bought_q  <= 1'b1;
					end
					if ((go_down && has_bought_q) || go_up)
						state_q <= (price_q == '0) ? ST_EMIT_ORD : ST_DIV;
					else if (final_q)
						state_q <= ST_EMIT_END;
					else
						state_q <= ST_IDLE;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_EMIT_ORD;
				end
				ST_EMIT_ORD: begin
					if (slot_free)
						state_q <= final_q ? ST_EMIT_END : ST_IDLE;
				end
				ST_EMIT_END: begin
					if (slot_free) begin
						short_sum_q   <= '0;
						long_sum_q    <= '0;
						tick_q        <= '0;
						wp_q          <= '0;
						short_above_q <= 1'b1;
						has_bought_q  <= 1'b0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				price_q <= tick_ch.price;
				final_q <= tick_ch.final_tick;
			end
			ST_RD_L: old_s_q <= s_full ? rd_q : '0;
			ST_UPD: ord_tick_q <= tick_q;
			ST_MUL_L: lhs_q <= product;
			ST_MUL_R: rhs_q <= product;
			ST_CMP: begin
				kind_q <= go_up ? KIND_BUY : KIND_SELL;
				qty_q  <= '1;
			end
			ST_DIV: begin
				if (div_done)
					qty_q <= div_quo;
			end
			ST_EMIT_ORD: begin
				if (slot_free) begin
					out_kind_q <= kind_q;
					out_tick_q <= ord_tick_q;
					out_qty_q  <= qty_q;
					out_tag_q  <= tag_q;
					out_last_q <= !final_q;
				end
			end
			ST_EMIT_END: begin
				if (slot_free) begin
					out_kind_q <= KIND_END;
					out_tick_q <= '0;
					out_qty_q  <= '0;
					out_tag_q  <= tag_q;
					out_last_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign tick_ch.ready        = (state_q == ST_IDLE);
	assign order_ch.valid       = out_valid_q;
	assign order_ch.order_kind  = out_kind_q;
	assign order_ch.tick_index  = out_tick_q;
	assign order_ch.quantity    = out_qty_q;
	assign order_ch.tag         = out_tag_q;
	assign order_ch.last_result = out_last_q;
endmodule

@@ sv/macs_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the crossover core, attached by bind.
// Depends on macs_pkg and moving_average_crossover_signal_core.

module macs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [macs_pkg::KIND_W-1:0]   out_kind,
	input logic [macs_pkg::TICK_W-1:0]   out_tick,
	input logic [macs_pkg::QTY_W-1:0]    out_qty,
	input logic                          out_last
);
	import macs_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one price at a time: busy right after taking one
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a transaction");

	// end marker has zero tick and quantity and closes the item
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_END |-> out_last && out_tick == '0 && out_qty == '0)
		else $error("malformed end marker");

	// a result that is not last must be an order (one that the core follows with an end marker)
	a_not_last_is_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_kind == KIND_BUY || out_kind == KIND_SELL)
		else $error("non-final result is not an order");
endmodule

bind moving_average_crossover_signal_core macs_checker u_macs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (tick_ch.valid),
	.in_ready  (tick_ch.ready),
	.out_valid (order_ch.valid),
	.out_ready (order_ch.ready),
	.out_kind  (order_ch.order_kind),
	.out_tick  (order_ch.tick_index),
	.out_qty   (order_ch.quantity),
	.out_last  (order_ch.last_result)
);

@@ test/moving_average_crossover_signal_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for moving_average_crossover_signal_core: price ticks in, buy/sell/end orders out.
// Depends on macs_pkg and the macs_in_if / macs_out_if channel interfaces.

module moving_average_crossover_signal_core_tb;
	import macs_pkg::*;

	localparam int HIST_DEPTH     = 256;
	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RAND_PHASES    = 12;
	localparam int PHASE_ITEMS    = 125;
	localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

	typedef struct packed {
		kind_t             kind;
		logic [TICK_W-1:0] tick;
		logic [QTY_W-1:0]  qty;
		logic [TAG_W-1:0]  tag;
		logic              last;
	} order_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	macs_in_if  tick_ch();
	macs_out_if order_ch();

	moving_average_crossover_signal_core #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tick_ch(tick_ch),
		.order_ch(order_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow registers and strategy state
	logic [LEN_W-1:0]   short_len_r;
	logic [LEN_W-1:0]   long_len_r;
	logic [CAP_W-1:0]   capital_r;
	logic [TAG_W-1:0]   tag_r;
	logic [PRICE_W-1:0] price_hist [HIST_DEPTH];
	logic [SUM_W-1:0]   short_sum;
	logic [SUM_W-1:0]   long_sum;
	logic [TICK_W-1:0]  tick_cnt;
	logic               short_above;
	logic               has_bought;

	order_t pending_orders[$];

	int mismatches = 0;
	int ticks_sent = 0;
	int buys_seen  = 0;
	int sells_seen = 0;
	int ends_seen  = 0;
	int quiet_cycles = 0;

	// stimulus control
	int          burst_left = 0;
	bit          gaps_on = 1'b1;
	bit          hold_req = 1'b0;
	int          series_left = 0;
	longint      walk_price;
	int unsigned walk_step;
	bit          walk_up = 1'b1;

	function automatic int unsigned window_len(input logic [LEN_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > HIST_DEPTH) return HIST_DEPTH;
		return 32'(raw);
	endfunction

	task automatic restart_series();
		short_sum   = '0;
		long_sum    = '0;
		tick_cnt    = '0;
		short_above = 1'b1;
		has_bought  = 1'b0;
	endtask

	// advance the crossover state by one price and queue the orders it yields
	task automatic predict_orders(input logic [PRICE_W-1:0] p, input logic fin);
		int unsigned       slen;
		int unsigned       llen;
		logic [TICK_W-1:0] tick;
		logic [SUM_W-1:0]  old_s;
		logic [SUM_W-1:0]  old_l;
		logic [63:0]       lhs;
		logic [63:0]       rhs;
		logic [QTY_W-1:0]  qty;
		kind_t             kind;
		bit                emit;
		order_t            o;
		slen  = window_len(short_len_r);
		llen  = window_len(long_len_r);
		tick  = tick_cnt;
		old_s = '0;
		old_l = '0;
		if (tick >= slen) old_s = SUM_W'(price_hist[(tick - slen) % HIST_DEPTH]);
		if (tick >= llen) old_l = SUM_W'(price_hist[(tick - llen) % HIST_DEPTH]);
		price_hist[tick % HIST_DEPTH] = p;
		short_sum = short_sum + SUM_W'(p) - old_s;
		long_sum  = long_sum + SUM_W'(p) - old_l;
		// averages compared without division
		lhs  = 64'(short_sum) * 64'(llen);
		rhs  = 64'(long_sum) * 64'(slen);
		emit = 1'b0;
		kind = KIND_BUY;
		if (short_above && rhs > lhs) begin
			short_above = 1'b0;
			if (has_bought) begin
				emit = 1'b1;
				kind = KIND_SELL;
			end
		end else if (!short_above && lhs > rhs) begin
			short_above = 1'b1;
			has_bought  = 1'b1;
			emit = 1'b1;
			kind = KIND_BUY;
		end
		if (emit) begin
			qty = (p == '0) ? '1 : QTY_W'((64'(capital_r) << 16) / 64'(p));
			o = '{kind, tick, qty, tag_r, !fin};
			pending_orders.push_back(o);
		end
		tick_cnt = tick + 1;
		if (fin) begin
			o = '{KIND_END, '0, '0, tag_r, 1'b1};
			pending_orders.push_back(o);
			restart_series();
		end
	endtask

	// input monitor: every accepted tick feeds the prediction
	always @(posedge clk) begin
		if (arst_n && tick_ch.valid && tick_ch.ready) begin
			ticks_sent++;
			predict_orders(tick_ch.price, tick_ch.final_tick);
		end
	end

	// order checker
	always @(posedge clk) begin
		order_t got;
		order_t want;
		if (arst_n && order_ch.valid && order_ch.ready) begin
			got = '{order_ch.order_kind, order_ch.tick_index, order_ch.quantity,
				order_ch.tag, order_ch.last_result};
			case (got.kind)
				KIND_BUY:  buys_seen++;
				KIND_SELL: sells_seen++;
				default:   ends_seen++;
			endcase
			if (pending_orders.size() == 0) begin
				$display("%0t: unexpected order, expected none, actual kind=%0d tick=%0d qty=%h tag=%h last=%b",
					$time, got.kind, got.tick, got.qty, got.tag, got.last);
				mismatches++;
			end else begin
				want = pending_orders.pop_front();
				if (got !== want) begin
					$display("%0t: order mismatch: expected kind=%0d tick=%0d qty=%h tag=%h last=%b",
						$time, want.kind, want.tick, want.qty, want.tag, want.last);
					$display("%0t:                 actual   kind=%0d tick=%0d qty=%h tag=%h last=%b",
						$time, got.kind, got.tick, got.qty, got.tag, got.last);
					mismatches++;
				end
			end
		end
	end

	// watchdog: too long without any transaction ends the run
	always @(posedge clk) begin
		if (!arst_n || (tick_ch.valid && tick_ch.ready) || (order_ch.valid && order_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d orders outstanding",
				$time, quiet_cycles, pending_orders.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// order receiver: stall styles of its own, plus a long hold on request
	initial begin : receiver
		int style_left;
		int style;
		int beat;
		style_left = 0;
		style = 0;
		beat = 0;
		order_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				order_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (style_left == 0) begin
					style = $urandom_range(0, 3);
					style_left = $urandom_range(20, 200);
				end
				style_left--;
				beat++;
				case (style)
					0: order_ch.ready <= 1'b1;
					1: order_ch.ready <= ($urandom_range(0, 3) != 0);
					2: order_ch.ready <= ($urandom_range(0, 4) == 0);
					default: order_ch.ready <= (beat % 7 < 3);
				endcase
			end
		end
	end

	// one price transaction, with bursts and random gaps in between
	task automatic send_tick(input logic [PRICE_W-1:0] p, input logic fin);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on)
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
		end
		if (gap > 0) begin
			@(negedge clk);
			tick_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		tick_ch.valid      <= 1'b1;
		tick_ch.price      <= p;
		tick_ch.final_tick <= fin;
		do @(posedge clk); while (!tick_ch.ready);
		burst_left--;
	endtask

	// stop sending and let the core go idle
	task automatic settle();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_orders.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] s, l, cap, tg);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SHORT_LEN;
		cfg_data  <= s;
		@(negedge clk);
		cfg_index <= REG_LONG_LEN;
		cfg_data  <= l;
		@(negedge clk);
		cfg_index <= REG_CAPITAL;
		cfg_data  <= cap;
		@(negedge clk);
		cfg_index <= REG_TAG;
		cfg_data  <= tg;
		@(negedge clk);
		cfg_we <= 1'b0;
		short_len_r = s[LEN_W-1:0];
		long_len_r  = l[LEN_W-1:0];
		capital_r   = cap[CAP_W-1:0];
		tag_r       = tg[TAG_W-1:0];
	endtask

	function automatic logic [PRICE_W-1:0] walk_next();
		longint nxt;
		longint step;
		if ($urandom_range(0, 11) == 0) walk_up = !walk_up;
		step = longint'($urandom_range(0, walk_step));
		nxt  = walk_up ? walk_price + step : walk_price - step;
		if (nxt < 0) nxt = 0;
		else if (nxt > longint'(PRICE_MAX)) nxt = longint'(PRICE_MAX);
		walk_price = nxt;
		return nxt[PRICE_W-1:0];
	endfunction

	// reset register values: high plateau, dip (no sell before a buy), spike, slump
	task automatic test_reset_defaults();
		logic [PRICE_W-1:0] p;
		for (int n = 0; n < 15; n++) begin
			p = (n < 5) ? 24'd9000 : (n < 9) ? 24'd100 : (n < 10) ? 24'd60000 : 24'd50;
			send_tick(p, n == 14);
		end
	endtask

	// clamped lengths, zero and full-scale prices and capital, order plus end marker
	task automatic test_extremes();
		settle();
		apply_settings(32'd0, 32'd2, 32'hFFFF_FFFF, 32'hA5);
		send_tick(24'd1000, 1'b0);
		send_tick(24'd500, 1'b0);
		send_tick(24'd0, 1'b0);
		send_tick(PRICE_MAX, 1'b0);
		send_tick(24'd0, 1'b0);
		send_tick(24'd100, 1'b1);
		send_tick(24'd7, 1'b1);
		settle();
		apply_settings(32'h1FF, 32'd0, 32'd0, 32'hFF);
		send_tick(24'd5, 1'b0);
		send_tick(24'd0, 1'b0);
		send_tick(24'd1, 1'b0);
		send_tick(24'd0, 1'b1);
	endtask

	// alternating prices cross on every tick after the first two while the receiver holds off
	task automatic test_output_stall();
		settle();
		apply_settings(32'd1, 32'd2, 32'd10000, 32'h3C);
		gaps_on = 1'b0;
		hold_req = 1'b1;
		for (int n = 0; n < 40; n++)
			send_tick((n % 2) ? 24'd2000 : 24'd1000, n == 39);
		gaps_on = 1'b1;
	endtask

	// random-walk series of random length under a sweep of settings
	task automatic test_random_series();
		logic [CFG_DATA_W-1:0] s_len;
		logic [CFG_DATA_W-1:0] l_len;
		logic [CFG_DATA_W-1:0] cap;
		logic [CFG_DATA_W-1:0] tg;
		logic [PRICE_W-1:0]    p;
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			cap = $urandom;
			tg  = $urandom_range(0, 255);
			case (phase)
				0: begin s_len = 1; l_len = 256; tg = 0; end
				1: begin s_len = 256; l_len = 1; cap = 32'hFFFF_FFFF; tg = 255; end
				2: begin s_len = 0; l_len = 3; end
				// upper data bits are dropped by the register width
				3: begin s_len = 32'h0000_0305; l_len = 32'hFFFF_FE10; cap = 0; end
				4: begin s_len = 8; l_len = 8; end
				default: begin
					s_len = $urandom_range(1, 24);
					l_len = $urandom_range(2, 80);
					if ($urandom_range(0, 2) == 0) s_len = $urandom_range(0, 511);
					if ($urandom_range(0, 2) == 0) l_len = $urandom_range(0, 511);
				end
			endcase
			settle();
			apply_settings(s_len, l_len, cap, tg);
			gaps_on = (phase % 3 != 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (series_left == 0) begin
					series_left = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 320)
						: $urandom_range(3, 60);
					walk_price = longint'($urandom_range(0, PRICE_MAX));
					walk_step  = 1 << $urandom_range(0, 20);
				end
				p = ($urandom_range(0, 11) == 0) ? PRICE_W'($urandom) : walk_next();
				send_tick(p, series_left == 1);
				series_left--;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		tick_ch.valid      = 1'b0;
		tick_ch.price      = '0;
		tick_ch.final_tick = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_SHORT_LEN;
		cfg_data  = '0;
		short_len_r = SHORT_LEN_RST;
		long_len_r  = LONG_LEN_RST;
		capital_r   = CAPITAL_RST;
		tag_r       = TAG_RST;
		restart_series();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_extremes();
		test_output_stall();
		test_random_series();
		settle();

		$display("Run covered %0d price ticks across short/long lengths 0..511 raw, capital 0..max,",
			ticks_sent);
		$display("and a %0d-cycle output hold: %0d buys, %0d sells, %0d series ends checked.",
			HOLD_CYCLES, buys_seen, sells_seen, ends_seen);
		if (mismatches == 0 && pending_orders.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
